// File: rtl/ptt_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer table package
// Item, result and table entry types, action and status codes, and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [1:0] ACT_REGISTER   = 2'd0;
  localparam logic [1:0] ACT_UNREGISTER = 2'd1;
  localparam logic [1:0] ACT_TICK       = 2'd2;
  localparam logic [1:0] ACT_NONE       = 2'd3;

  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_PRESENT    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_MARKED     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND   = 3'd4;
  localparam logic [2:0] ST_FIRED      = 3'd5;
  localparam logic [2:0] ST_DONE       = 3'd6;

  localparam logic [1:0] WK_APPEND  = 2'd0;
  localparam logic [1:0] WK_MARK    = 2'd1;
  localparam logic [1:0] WK_COMPACT = 2'd2;

  localparam logic [1:0] IDS_ITEM  = 2'd0;
  localparam logic [1:0] IDS_ENTRY = 2'd1;
  localparam logic [1:0] IDS_ZERO  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  timer_id;
    logic [31:0] interval_ticks;
    logic [47:0] now;
  } ptt_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] timer_id_res;
    logic       last;
  } ptt_out_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] interval;
    logic [47:0] deadline;
    logic        marked;
  } ptt_entry_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] status;
    logic [1:0] id_sel;
    logic       last;
    logic       wr_en;
    logic [1:0] wr_kind;
    logic       idx_inc;
    logic       wr_inc;
    logic       count_load;
    logic       count_inc;
  } ptt_cmd_t;

  typedef struct packed {
    logic       scan_end;
    logic       hit;
    logic       marked;
    logic       fire;
    logic       full;
    logic [1:0] action;
  } ptt_stat_t;

endpackage

// File: rtl/ptt_datapath.sv
// ---------------------------------------------------------------------------
// Periodic timer table datapath
// Entry memory, scan and compaction pointers, entry count, deadline adder
// and the result register.
// ---------------------------------------------------------------------------
module ptt_datapath #(
  parameter int MAX_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptt_pkg::ptt_in_t  in_item,
  input  ptt_pkg::ptt_cmd_t cmd,
  output ptt_pkg::ptt_stat_t stat,
  output logic              out_valid,
  output ptt_pkg::ptt_out_t out_res
);

  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

  ptt_pkg::ptt_entry_t mem_r [MAX_TIMERS];
  ptt_pkg::ptt_entry_t rdata_r;
  ptt_pkg::ptt_entry_t wdata;
  ptt_pkg::ptt_in_t    item_r;
  ptt_pkg::ptt_out_t   out_res_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       wr_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic [AW-1:0]       waddr;
  logic [31:0]         add_ival;
  logic [47:0]         sum;
  logic                fire;
  logic [7:0]          res_id;

  assign fire     = rdata_r.deadline < item_r.now;
  assign add_ival = (cmd.wr_kind == ptt_pkg::WK_APPEND) ? item_r.interval_ticks
                                                        : rdata_r.interval;
  assign sum      = item_r.now + {16'd0, add_ival};

  always_comb begin
    wdata = rdata_r;
    waddr = idx_r[AW-1:0];
    case (cmd.wr_kind)
      ptt_pkg::WK_APPEND: begin
        waddr          = count_r[AW-1:0];
        wdata.id       = item_r.timer_id;
        wdata.interval = item_r.interval_ticks;
        wdata.deadline = sum;
        wdata.marked   = 1'b0;
      end
      ptt_pkg::WK_MARK: begin
        waddr        = idx_r[AW-1:0];
        wdata.marked = 1'b1;
      end
      ptt_pkg::WK_COMPACT: begin
        waddr          = wr_r[AW-1:0];
        wdata.deadline = fire ? sum : rdata_r.deadline;
        wdata.marked   = 1'b0;
      end
      default: begin
        waddr = idx_r[AW-1:0];
        wdata = rdata_r;
      end
    endcase
  end

  always_comb begin
    case (cmd.id_sel)
      ptt_pkg::IDS_ITEM:  res_id = item_r.timer_id;
      ptt_pkg::IDS_ENTRY: res_id = rdata_r.id;
      default:            res_id = 8'd0;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_load) begin
      count_nxt = wr_r;
    end else if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      idx_r  <= '0;
      wr_r   <= '0;
    end else begin
      if (cmd.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.wr_inc) begin
        wr_r <= wr_r + CW'(1);
      end
    end
    if (cmd.emit) begin
      out_res_r.status       <= cmd.status;
      out_res_r.timer_id_res <= res_id;
      out_res_r.last         <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign stat.scan_end = idx_r == count_r;
  assign stat.hit      = rdata_r.id == item_r.timer_id;
  assign stat.marked   = rdata_r.marked;
  assign stat.fire     = fire;
  assign stat.full     = count_r == CW'(MAX_TIMERS);
  assign stat.action   = item_r.action;

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/ptt_ctrl.sv
// ---------------------------------------------------------------------------
// Periodic timer table controller
// Sequences lookups, appends, marks and the tick walk over the table.
// ---------------------------------------------------------------------------
module ptt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_action,
  input  ptt_pkg::ptt_stat_t stat,
  output logic               busy,
  output ptt_pkg::ptt_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start && in_action != ptt_pkg::ACT_NONE) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (stat.scan_end) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.id_sel = ptt_pkg::IDS_ITEM;
          state_nxt  = S_IDLE;
          case (stat.action)
            ptt_pkg::ACT_REGISTER: begin
              if (stat.full) begin
                cmd.status = ptt_pkg::ST_FULL;
              end else begin
                cmd.status    = ptt_pkg::ST_REGISTERED;
                cmd.wr_en     = 1'b1;
                cmd.wr_kind   = ptt_pkg::WK_APPEND;
                cmd.count_inc = 1'b1;
              end
            end
            ptt_pkg::ACT_UNREGISTER: begin
              cmd.status = ptt_pkg::ST_NOTFOUND;
            end
            default: begin
              cmd.status     = ptt_pkg::ST_DONE;
              cmd.id_sel     = ptt_pkg::IDS_ZERO;
              cmd.count_load = 1'b1;
            end
          endcase
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        state_nxt   = S_RD;
        cmd.idx_inc = 1'b1;
        case (stat.action)
          ptt_pkg::ACT_REGISTER: begin
            if (stat.hit) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.status = ptt_pkg::ST_PRESENT;
              cmd.id_sel = ptt_pkg::IDS_ITEM;
              state_nxt  = S_IDLE;
            end
          end
          ptt_pkg::ACT_UNREGISTER: begin
            if (stat.hit) begin
              cmd.emit    = 1'b1;
              cmd.last    = 1'b1;
              cmd.status  = ptt_pkg::ST_MARKED;
              cmd.id_sel  = ptt_pkg::IDS_ITEM;
              cmd.wr_en   = 1'b1;
              cmd.wr_kind = ptt_pkg::WK_MARK;
              state_nxt   = S_IDLE;
            end
          end
          default: begin
            if (!stat.marked) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_kind = ptt_pkg::WK_COMPACT;
              cmd.wr_inc  = 1'b1;
              if (stat.fire) begin
                cmd.emit   = 1'b1;
                cmd.status = ptt_pkg::ST_FIRED;
                cmd.id_sel = ptt_pkg::IDS_ENTRY;
              end
            end
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// File: rtl/periodic_timer_table.sv
// Scan: each entry scanned passes through a memory read state and then an evaluate
// state; a tick walks all entries in use, a lookup that matches stops there and
// answers from the evaluate state.
// Items: a new item is accepted only while idle, so one item is finished before the next is taken.
// Results: one strobe cycle each, fired results during the walk, done last.
// Reset: synchronous, active low; the table comes up empty, no clearing pass.
// ---------------------------------------------------------------------------
// Periodic timer table
// Insertion-ordered table of periodic timers with register, unregister and
// tick items; a tick fires due timers and compacts out marked entries.
// ---------------------------------------------------------------------------
module periodic_timer_table #(
  parameter int MAX_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ptt_pkg::ptt_in_t  in_item,
  output logic              busy,
  output logic              out_valid,
  output ptt_pkg::ptt_out_t out_res
);

  ptt_pkg::ptt_cmd_t  cmd;
  ptt_pkg::ptt_stat_t stat;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  ptt_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: test/ptt_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Periodic timer table checker
// Watches the item and result channels, keeps its own copy of the timer
// table, works out the results each accepted item should cause and compares
// every result strobe against the oldest outstanding one, field by field.
// ---------------------------------------------------------------------------
module ptt_checker #(
  parameter int MAX_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ptt_pkg::ptt_in_t  in_item,
  input  logic              out_valid,
  input  ptt_pkg::ptt_out_t out_res,
  output int                fails,
  output int                pending,
  output int                checked,
  output int                fired
);

  localparam int QD = 64;

  ptt_pkg::ptt_entry_t slots [MAX_TIMERS];
  int unsigned         used;
  ptt_pkg::ptt_out_t   awaited [QD];
  logic [5:0]          q_head;
  logic [5:0]          q_tail;
  int                  q_count;

  function automatic void note_reply(input logic [2:0] status, input logic [7:0] id,
                                     input logic last);
    ptt_pkg::ptt_out_t r;
    r.status       = status;
    r.timer_id_res = id;
    r.last         = last;
    if (q_count >= QD) begin
      $error("result queue overflow");
      fails++;
    end else begin
      awaited[q_tail] = r;
      q_tail          = q_tail + 6'd1;
      q_count++;
    end
  endfunction

  function automatic int find_slot(input logic [7:0] id);
    for (int i = 0; i < used; i++) begin
      if (slots[i].id == id) return i;
    end
    return -1;
  endfunction

  task automatic advance_timer_table(input ptt_pkg::ptt_in_t it);
    int                  pos;
    int                  wr;
    ptt_pkg::ptt_entry_t e;
    case (it.action)
      ptt_pkg::ACT_REGISTER: begin
        pos = find_slot(it.timer_id);
        if (pos >= 0) begin
          note_reply(ptt_pkg::ST_PRESENT, it.timer_id, 1'b1);
        end else if (used >= MAX_TIMERS) begin
          note_reply(ptt_pkg::ST_FULL, it.timer_id, 1'b1);
        end else begin
          e.id           = it.timer_id;
          e.interval     = it.interval_ticks;
          e.deadline     = it.now + {16'd0, it.interval_ticks};
          e.marked       = 1'b0;
          slots[used]    = e;
          used++;
          note_reply(ptt_pkg::ST_REGISTERED, it.timer_id, 1'b1);
        end
      end
      ptt_pkg::ACT_UNREGISTER: begin
        pos = find_slot(it.timer_id);
        if (pos >= 0) begin
          slots[pos].marked = 1'b1;
          note_reply(ptt_pkg::ST_MARKED, it.timer_id, 1'b1);
        end else begin
          note_reply(ptt_pkg::ST_NOTFOUND, it.timer_id, 1'b1);
        end
      end
      ptt_pkg::ACT_TICK: begin
        wr = 0;
        for (int rd = 0; rd < used; rd++) begin
          e = slots[rd];
          if (!e.marked) begin
            if (e.deadline < it.now) begin
              note_reply(ptt_pkg::ST_FIRED, e.id, 1'b0);
              e.deadline = it.now + {16'd0, e.interval};
            end
            slots[wr] = e;
            wr++;
          end
        end
        for (int rd = wr; rd < MAX_TIMERS; rd++) slots[rd] = '0;
        used = wr;
        note_reply(ptt_pkg::ST_DONE, 8'd0, 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ptt_pkg::ptt_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_TIMERS; i++) slots[i] = '0;
      used    = 0;
      q_head  = '0;
      q_tail  = '0;
      q_count = 0;
      fails   = 0;
      checked = 0;
      fired   = 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (q_count == 0) begin
          $error("unexpected result: status %0d, id %0d, last %0d",
                 out_res.status, out_res.timer_id_res, out_res.last);
          fails++;
        end else begin
          want   = awaited[q_head];
          q_head = q_head + 6'd1;
          q_count--;
          checked++;
          if (want.status == ptt_pkg::ST_FIRED) fired++;
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            fails++;
          end
          if (out_res.timer_id_res !== want.timer_id_res) begin
            $error("timer_id_res: expected %0d, got %0d",
                   want.timer_id_res, out_res.timer_id_res);
            fails++;
          end
          if (out_res.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_res.last);
            fails++;
          end
        end
      end
      if (start && !busy) advance_timer_table(in_item);
      pending <= q_count;
    end
  end

endmodule

// File: test/periodic_timer_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Periodic timer table testbench
// Drives directed and random register, unregister and tick items with
// random sender gaps; the checker predicts and compares all results.
// ---------------------------------------------------------------------------
module periodic_timer_table_tb;

  localparam int MAX_TIMERS = 16;
  localparam int ITEMS      = 420;
  localparam int CALM_TAIL  = 60;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  ptt_pkg::ptt_in_t  in_item = '0;
  logic              busy;
  logic              out_valid;
  ptt_pkg::ptt_out_t out_res;

  int fails, pending, checked, fired;
  int n_reg, n_unreg, n_tick, n_ignored;

  always #5 clk = ~clk;

  periodic_timer_table #(.MAX_TIMERS(MAX_TIMERS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  ptt_checker #(.MAX_TIMERS(MAX_TIMERS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_res   (out_res),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked),
    .fired     (fired)
  );

  function automatic ptt_pkg::ptt_in_t make_item(input logic [1:0] action,
                                                 input logic [7:0] id,
                                                 input logic [31:0] interval,
                                                 input logic [47:0] now);
    ptt_pkg::ptt_in_t it;
    it.action         = action;
    it.timer_id       = id;
    it.interval_ticks = interval;
    it.now            = now;
    return it;
  endfunction

  task automatic put_item(input ptt_pkg::ptt_in_t it);
    @(negedge clk);
    in_item <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (it.action)
      ptt_pkg::ACT_REGISTER:   n_reg++;
      ptt_pkg::ACT_UNREGISTER: n_unreg++;
      ptt_pkg::ACT_TICK:       n_tick++;
      default:                 n_ignored++;
    endcase
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= make_item(2'($urandom), 8'($urandom), $urandom, 48'({$urandom, $urandom}));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    ptt_pkg::ptt_in_t it;
    logic [47:0]      now_t;
    int               r;
    int               issued;
    n_reg     = 0;
    n_unreg   = 0;
    n_tick    = 0;
    n_ignored = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    put_item(make_item(ptt_pkg::ACT_TICK, 8'd0, 32'd0, 48'd0));
    put_item(make_item(ptt_pkg::ACT_REGISTER, 8'd0, 32'd0, 48'd0));
    put_item(make_item(ptt_pkg::ACT_REGISTER, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    put_item(make_item(ptt_pkg::ACT_REGISTER, 8'd0, 32'd5, 48'd3));
    put_item(make_item(ptt_pkg::ACT_UNREGISTER, 8'd7, 32'd0, 48'd3));
    put_item(make_item(ptt_pkg::ACT_UNREGISTER, 8'd0, 32'd0, 48'd3));
    put_item(make_item(ptt_pkg::ACT_UNREGISTER, 8'd0, 32'd0, 48'd3));
    put_item(make_item(ptt_pkg::ACT_REGISTER, 8'd0, 32'd9, 48'd3));
    put_item(make_item(ptt_pkg::ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    put_item(make_item(ptt_pkg::ACT_TICK, 8'd0, 32'd0, 48'd1));
    for (int k = 16; k < 31; k++) begin
      put_item(make_item(ptt_pkg::ACT_REGISTER, 8'(k), 32'(3 * k), 48'd2));
    end
    put_item(make_item(ptt_pkg::ACT_REGISTER, 8'h80, 32'd1, 48'd2));
    put_item(make_item(ptt_pkg::ACT_TICK, 8'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
    drain();

    now_t  = 48'd100;
    issued = 0;
    while (issued < ITEMS) begin
      if (issued % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       now_t = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 4000));
          1:       now_t = 48'({$urandom, $urandom});
          default: ;
        endcase
      end
      now_t = now_t + 48'($urandom_range(0, 80));
      it.now      = now_t;
      it.timer_id = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
      case ($urandom_range(0, 9))
        0:       it.interval_ticks = $urandom;
        1, 2:    it.interval_ticks = $urandom_range(0, 5000);
        default: it.interval_ticks = $urandom_range(0, 150);
      endcase
      r = $urandom_range(0, 99);
      if (r < 45)      it.action = ptt_pkg::ACT_REGISTER;
      else if (r < 70) it.action = ptt_pkg::ACT_UNREGISTER;
      else if (r < 96) it.action = ptt_pkg::ACT_TICK;
      else             it.action = ptt_pkg::ACT_NONE;
      put_item(it);
      if (it.action != ptt_pkg::ACT_NONE) begin
        issued++;
        if (issued % 150 == 0) drain();
        else if (issued < ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
          hold_off($urandom_range(1, 12));
      end
    end

    drain();
    repeat (2 * MAX_TIMERS + 12) @(negedge clk);
    $display("Covered %0d register, %0d unregister, %0d tick and %0d unused-code items",
             n_reg, n_unreg, n_tick, n_ignored);
    $display("Compared %0d results, %0d of them timer firings", checked, fired);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: periodic_timer_table.f
rtl/ptt_pkg.sv
rtl/ptt_datapath.sv
rtl/ptt_ctrl.sv
rtl/periodic_timer_table.sv
test/ptt_checker.sv
test/periodic_timer_table_tb.sv
